@@ sv/gms_pkg.sv @@
`timescale 1ns / 1ps
package gms_pkg;

  // Grid and candidate list capacity
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int MAX_CAND = 64;

  localparam int ROW_W      = $clog2(MAX_ROWS + 1);
  localparam int COL_W      = $clog2(MAX_COLS + 1);
  localparam int GRID_CELLS = MAX_ROWS * MAX_COLS;
  localparam int GA_W       = $clog2(GRID_CELLS);
  localparam int GC_W       = $clog2(GRID_CELLS + 1);
  localparam int CI_W       = (MAX_CAND > 1) ? $clog2(MAX_CAND) : 1;
  localparam int CC_W       = $clog2(MAX_CAND + 1);

  localparam int SCORE_W = 16;
  localparam int POS_W   = 14;
  localparam int STEP_W  = 8;
  localparam int DIM_W   = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int PROD_W  = DIM_W + STEP_W;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef struct packed {
    logic [POS_W-1:0]          x;
    logic [POS_W-1:0]          y;
    logic signed [SCORE_W-1:0] score;
  } cand_t;

  typedef struct packed {
    logic lt;
    logic le;
    logic gt;
    logic close;
  } cmp_res_t;

  // Clamp a scaled position to the position field
  function automatic logic [POS_W-1:0] sat_pos(input logic [PROD_W-1:0] v);
    logic [POS_W-1:0] res;
    if (v > PROD_W'(POS_MAX)) res = POS_MAX;
    else res = v[POS_W-1:0];
    return res;
  endfunction

endpackage

@@ sv/gms_grid_mem.sv @@
`timescale 1ns / 1ps
module gms_grid_mem (
  input  logic                               clk,
  input  logic                               we,
  input  logic [gms_pkg::GA_W-1:0]           waddr,
  input  logic signed [gms_pkg::SCORE_W-1:0] wdata,
  input  logic [gms_pkg::GA_W-1:0]           raddr,
  output logic signed [gms_pkg::SCORE_W-1:0] rdata
);
  import gms_pkg::*;

  logic signed [SCORE_W-1:0] mem [GRID_CELLS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

@@ sv/gms_cand_mem.sv @@
`timescale 1ns / 1ps
module gms_cand_mem (
  input  logic                     clk,
  input  logic                     we,
  input  logic [gms_pkg::CI_W-1:0] waddr,
  input  gms_pkg::cand_t           wdata,
  input  logic [gms_pkg::CI_W-1:0] raddr,
  output gms_pkg::cand_t           rdata
);
  import gms_pkg::*;

  cand_t mem [MAX_CAND];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

@@ sv/gms_cmp.sv @@
`timescale 1ns / 1ps
module gms_cmp (
  input  logic signed [gms_pkg::SCORE_W-1:0] sa,
  input  logic signed [gms_pkg::SCORE_W-1:0] sb,
  input  logic [gms_pkg::POS_W-1:0]          xa,
  input  logic [gms_pkg::POS_W-1:0]          xb,
  input  logic [gms_pkg::POS_W-1:0]          ya,
  input  logic [gms_pkg::POS_W-1:0]          yb,
  input  logic [gms_pkg::POS_W-1:0]          xd,
  input  logic [gms_pkg::POS_W-1:0]          yd,
  output gms_pkg::cmp_res_t                  res
);
  import gms_pkg::*;

  logic [POS_W-1:0] dx;
  logic [POS_W-1:0] dy;

  // Absolute gaps
  assign dx = (xa > xb) ? (xa - xb) : (xb - xa);
  assign dy = (ya > yb) ? (ya - yb) : (yb - ya);

  // Score order and closeness
  assign res.lt    = sa < sb;
  assign res.le    = sa <= sb;
  assign res.gt    = sa > sb;
  assign res.close = (dx < xd) && (dy < yd);
endmodule

@@ sv/grid_minimum_suppression.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake           | Payload
// in_      | input     | in_valid/in_stall   | in_score
// out_     | output    | out_valid/out_stall | out_x_pos, out_y_pos, out_found,
//          |           |                     | out_overflow, out_last
// apb      | input     | psel/penable/pready | paddr, pwdata, prdata
// Scores are taken one per cycle until the grid is complete.
// The last score starts the search: each cell takes five reads of the
// score memory's single read port through one shared compare unit, then
// a pair pass over the candidates, then the emit pass, which the output
// stall can hold. No score is taken from the grid's last score until
// the last result item leaves. Reset is synchronous and needs no clearing pass.
module grid_minimum_suppression (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [gms_pkg::SCORE_W-1:0] in_score,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gms_pkg::POS_W-1:0]          out_x_pos,
  output logic [gms_pkg::POS_W-1:0]          out_y_pos,
  output logic                               out_found,
  output logic                               out_overflow,
  output logic                               out_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import gms_pkg::*;

  typedef enum logic [2:0] {
    REG_ROWS = 3'd0,
    REG_COLS = 3'd1,
    REG_XSTEP = 3'd2,
    REG_YSTEP = 3'd3,
    REG_THR = 3'd4,
    REG_XDIST = 3'd5,
    REG_YDIST = 3'd6
  } reg_idx_t;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b00000001,
    S_FIND  = 8'b00000010,
    S_MLI   = 8'b00000100,
    S_MLD   = 8'b00001000,
    S_MJ    = 8'b00010000,
    S_ESCAN = 8'b00100000,
    S_ERD   = 8'b01000000,
    S_EOUT  = 8'b10000000
  } state_t;

  state_t state_r;

  logic [6:0]                rows_cfg_r;
  logic [6:0]                cols_cfg_r;
  logic [STEP_W-1:0]         xstep_r;
  logic [STEP_W-1:0]         ystep_r;
  logic signed [SCORE_W-1:0] thr_r;
  logic [POS_W-1:0]          xdist_r;
  logic [POS_W-1:0]          ydist_r;

  logic [GC_W-1:0]           load_cnt_r;
  logic [ROW_W-1:0]          r_r;
  logic [COL_W-1:0]          c_r;
  logic [GC_W-1:0]           base_r;
  logic [2:0]                k_r;
  logic signed [SCORE_W-1:0] s_r;
  logic                      ok_r;
  logic [CC_W-1:0]           cand_cnt_r;
  logic                      ovf_r;
  logic [MAX_CAND-1:0]       marks_r;
  logic [CC_W-1:0]           i_r;
  logic [CC_W-1:0]           j_r;
  logic [CI_W-1:0]           pj_r;
  cand_t                     ci_r;
  logic [CC_W-1:0]           e_r;
  logic                      any_r;

  logic                      out_valid_r;
  logic [POS_W-1:0]          out_x_r;
  logic [POS_W-1:0]          out_y_r;
  logic                      out_found_r;
  logic                      out_ovf_r;
  logic                      out_last_r;

  logic [ROW_W-1:0]          rows;
  logic [COL_W-1:0]          cols;
  logic [GC_W-1:0]           total;
  logic [GC_W-1:0]           load_cnt1;
  logic                      in_acc;
  logic                      cfg_wr;
  reg_idx_t                  cfg_idx;

  logic [GC_W-1:0]           ctr_addr;
  logic [GC_W-1:0]           g_addr;
  logic                      has_up;
  logic                      has_dn;
  logic                      has_lf;
  logic                      has_rt;
  logic signed [SCORE_W-1:0] g_rd;

  cand_t                     c_rd;
  cand_t                     c_wd;
  logic                      c_we;
  logic [CI_W-1:0]           c_raddr;
  logic                      hit;
  logic [CC_W-1:0]           cand_cnt_nxt;

  logic signed [SCORE_W-1:0] sa;
  logic signed [SCORE_W-1:0] sb;
  cmp_res_t                  cmp;

  logic [MAX_CAND-1:0]       surv;
  logic [MAX_CAND-1:0]       later;
  logic                      is_last;
  logic [CI_W-1:0]           mark_idx;

  // Effective grid size, clamped to the capacity, with zero taken as one
  always_comb begin
    if (rows_cfg_r == 7'd0) rows = ROW_W'(1);
    else if (int'(rows_cfg_r) > MAX_ROWS) rows = ROW_W'(MAX_ROWS);
    else rows = ROW_W'(rows_cfg_r);
    if (cols_cfg_r == 7'd0) cols = COL_W'(1);
    else if (int'(cols_cfg_r) > MAX_COLS) cols = COL_W'(MAX_COLS);
    else cols = COL_W'(cols_cfg_r);
  end

  assign total     = GC_W'(rows) * GC_W'(cols);
  assign load_cnt1 = load_cnt_r + GC_W'(1);
  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      REG_ROWS:  prdata = {25'd0, rows_cfg_r};
      REG_COLS:  prdata = {25'd0, cols_cfg_r};
      REG_XSTEP: prdata = {24'd0, xstep_r};
      REG_YSTEP: prdata = {24'd0, ystep_r};
      REG_THR:   prdata = {{16{thr_r[SCORE_W-1]}}, thr_r};
      REG_XDIST: prdata = {18'd0, xdist_r};
      REG_YDIST: prdata = {18'd0, ydist_r};
      default:   prdata = 32'd0;
    endcase
  end

  // Neighbor addresses, edges clamped to the cell itself
  assign has_up   = (r_r != '0);
  assign has_dn   = ((ROW_W + 1)'(r_r) + (ROW_W + 1)'(1)) < (ROW_W + 1)'(rows);
  assign has_lf   = (c_r != '0);
  assign has_rt   = ((COL_W + 1)'(c_r) + (COL_W + 1)'(1)) < (COL_W + 1)'(cols);
  assign ctr_addr = base_r + GC_W'(c_r);

  always_comb begin
    case (k_r)
      3'd1:    g_addr = has_up ? (ctr_addr - GC_W'(cols)) : ctr_addr;
      3'd2:    g_addr = has_dn ? (ctr_addr + GC_W'(cols)) : ctr_addr;
      3'd3:    g_addr = has_lf ? (ctr_addr - GC_W'(1)) : ctr_addr;
      3'd4:    g_addr = has_rt ? (ctr_addr + GC_W'(1)) : ctr_addr;
      default: g_addr = ctr_addr;
    endcase
  end

  gms_grid_mem u_grid (
    .clk   (clk),
    .we    (in_acc),
    .waddr (load_cnt_r[GA_W-1:0]),
    .wdata (in_score),
    .raddr (g_addr[GA_W-1:0]),
    .rdata (g_rd)
  );

  // Shared compare unit operands
  always_comb begin
    if (state_r == S_FIND && k_r == 3'd1) begin
      sa = g_rd;
      sb = thr_r;
    end else if (state_r == S_FIND) begin
      sa = s_r;
      sb = g_rd;
    end else begin
      sa = ci_r.score;
      sb = c_rd.score;
    end
  end

  gms_cmp u_cmp (
    .sa  (sa),
    .sb  (sb),
    .xa  (ci_r.x),
    .xb  (c_rd.x),
    .ya  (ci_r.y),
    .yb  (c_rd.y),
    .xd  (xdist_r),
    .yd  (ydist_r),
    .res (cmp)
  );

  // Candidate push at the last neighbor compare
  assign hit  = (state_r == S_FIND) && (k_r == 3'd5) && ok_r && cmp.le;
  assign c_we = hit && (int'(cand_cnt_r) < MAX_CAND);
  assign cand_cnt_nxt = cand_cnt_r + (c_we ? CC_W'(1) : CC_W'(0));
  assign c_wd.x     = sat_pos(PROD_W'(r_r) * PROD_W'(xstep_r));
  assign c_wd.y     = sat_pos(PROD_W'(c_r) * PROD_W'(ystep_r));
  assign c_wd.score = s_r;

  always_comb begin
    case (state_r)
      S_MLI:        c_raddr = i_r[CI_W-1:0];
      S_MLD, S_MJ:  c_raddr = j_r[CI_W-1:0];
      default:      c_raddr = e_r[CI_W-1:0];
    endcase
  end

  gms_cand_mem u_cand (
    .clk   (clk),
    .we    (c_we),
    .waddr (cand_cnt_r[CI_W-1:0]),
    .wdata (c_wd),
    .raddr (c_raddr),
    .rdata (c_rd)
  );

  // Survivor mask and last-survivor test
  always_comb begin
    for (int n = 0; n < MAX_CAND; n++) begin
      surv[n]  = !marks_r[n] && (n < int'(cand_cnt_r));
      later[n] = (n > int'(e_r));
    end
  end
  assign is_last  = ((surv & later) == '0);
  assign mark_idx = cmp.gt ? i_r[CI_W-1:0] : pj_r;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      rows_cfg_r  <= 7'd64;
      cols_cfg_r  <= 7'd64;
      xstep_r     <= 8'd5;
      ystep_r     <= 8'd5;
      thr_r       <= 16'sd819;
      xdist_r     <= 14'd80;
      ydist_r     <= 14'd200;
      load_cnt_r  <= '0;
      cand_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_ROWS:  rows_cfg_r <= pwdata[6:0];
          REG_COLS:  cols_cfg_r <= pwdata[6:0];
          REG_XSTEP: xstep_r    <= pwdata[7:0];
          REG_YSTEP: ystep_r    <= pwdata[7:0];
          REG_THR:   thr_r      <= pwdata[15:0];
          REG_XDIST: xdist_r    <= pwdata[13:0];
          REG_YDIST: ydist_r    <= pwdata[13:0];
          default: ;
        endcase
      end

      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (load_cnt1 >= total) begin
              load_cnt_r <= '0;
              r_r        <= '0;
              c_r        <= '0;
              base_r     <= '0;
              k_r        <= 3'd0;
              state_r    <= S_FIND;
            end else begin
              load_cnt_r <= load_cnt1;
            end
          end
        end

        S_FIND: begin
          case (k_r)
            3'd0: k_r <= 3'd1;
            3'd1: begin
              s_r  <= g_rd;
              ok_r <= cmp.lt;
              k_r  <= 3'd2;
            end
            3'd5: begin
              // Push or flag, then advance to the next cell
              if (hit && !c_we) ovf_r <= 1'b1;
              cand_cnt_r <= cand_cnt_nxt;
              k_r <= 3'd0;
              if (has_rt) begin
                c_r <= c_r + COL_W'(1);
              end else begin
                c_r    <= '0;
                r_r    <= r_r + ROW_W'(1);
                base_r <= base_r + GC_W'(cols);
                if (!has_dn) begin
                  i_r <= '0;
                  e_r <= '0;
                  any_r <= 1'b0;
                  state_r <= (cand_cnt_nxt != '0) ? S_MLI : S_ESCAN;
                end
              end
            end
            default: begin
              ok_r <= ok_r && cmp.le;
              k_r  <= k_r + 3'd1;
            end
          endcase
        end

        S_MLI: begin
          j_r     <= '0;
          state_r <= S_MLD;
        end

        S_MLD: begin
          ci_r    <= c_rd;
          pj_r    <= j_r[CI_W-1:0];
          j_r     <= j_r + CC_W'(1);
          state_r <= S_MJ;
        end

        S_MJ: begin
          // Mark the higher score of a close pair
          if (pj_r != i_r[CI_W-1:0] && cmp.close) marks_r[mark_idx] <= 1'b1;
          if (j_r < cand_cnt_r) begin
            pj_r <= j_r[CI_W-1:0];
            j_r  <= j_r + CC_W'(1);
          end else if (i_r + CC_W'(1) == cand_cnt_r) begin
            state_r <= S_ESCAN;
          end else begin
            i_r     <= i_r + CC_W'(1);
            state_r <= S_MLI;
          end
        end

        S_ESCAN: begin
          if (e_r == cand_cnt_r) begin
            if (any_r) begin
              cand_cnt_r <= '0;
              marks_r    <= '0;
              ovf_r      <= 1'b0;
              state_r    <= S_LOAD;
            end else begin
              out_valid_r <= 1'b1;
              out_x_r     <= '0;
              out_y_r     <= '0;
              out_found_r <= 1'b0;
              out_ovf_r   <= ovf_r;
              out_last_r  <= 1'b1;
              state_r     <= S_EOUT;
            end
          end else if (surv[e_r[CI_W-1:0]]) begin
            state_r <= S_ERD;
          end else begin
            e_r <= e_r + CC_W'(1);
          end
        end

        S_ERD: begin
          out_valid_r <= 1'b1;
          out_x_r     <= c_rd.x;
          out_y_r     <= c_rd.y;
          out_found_r <= 1'b1;
          out_ovf_r   <= ovf_r;
          out_last_r  <= is_last;
          any_r       <= 1'b1;
          state_r     <= S_EOUT;
        end

        S_EOUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              cand_cnt_r <= '0;
              marks_r    <= '0;
              ovf_r      <= 1'b0;
              state_r    <= S_LOAD;
            end else begin
              e_r     <= e_r + CC_W'(1);
              state_r <= S_ESCAN;
            end
          end
        end

        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_x_pos    = out_x_r;
  assign out_y_pos    = out_y_r;
  assign out_found    = out_found_r;
  assign out_overflow = out_ovf_r;
  assign out_last     = out_last_r;

  // A result item is shown only while waiting for it to leave
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_EOUT)
    else $error("result item outside output state");

  // The empty result is always the last one
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> out_last)
    else $error("empty result not marked last");

  // After the last item leaves, scores are taken again
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !in_stall)
    else $error("input not reopened after last item");

  // The candidate list never grows past capacity
  a_cand_cap: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cand_cnt_r) <= MAX_CAND)
    else $error("candidate count past capacity");
endmodule
